@@ src/pal_pkg.sv @@
// Shared types, field widths and operation codes for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

  localparam int MODE_W   = 3;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef logic [MODE_W-1:0]          pal_mode_t;
  typedef logic signed [WORD_W-1:0]   pal_word_t;
  typedef logic [POS_W-1:0]           pal_pos_t;
  typedef logic [STATUS_W-1:0]        pal_status_t;
  typedef logic [COUNT_W-1:0]         pal_count_t;

  localparam pal_mode_t MODE_APPEND = 3'd0;
  localparam pal_mode_t MODE_INSERT = 3'd1;
  localparam pal_mode_t MODE_REMOVE = 3'd2;
  localparam pal_mode_t MODE_READ   = 3'd3;
  localparam pal_mode_t MODE_WRITE  = 3'd4;

  localparam pal_status_t ST_OK    = 2'd0;
  localparam pal_status_t ST_INDEX = 2'd1;
  localparam pal_status_t ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DRAIN,
    S_FINAL,
    S_READ,
    S_DONE
  } pal_state_t;

  typedef struct packed {
    pal_word_t   read_value;
    pal_status_t status;
    pal_count_t  count;
  } pal_result_t;

endpackage

@@ src/pal_store.sv @@
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pal_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  pal_pkg::pal_word_t  wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output pal_pkg::pal_word_t  rd_data
);
  import pal_pkg::*;

  pal_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/pal_ctrl.sv @@
// Operation sequencer: bound checks, count, and the one-entry-per-cycle shift engine.
`timescale 1ns / 1ps

module pal_ctrl #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  pal_pkg::pal_mode_t    mode,
  input  pal_pkg::pal_word_t    value,
  input  pal_pkg::pal_pos_t     position,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pal_pkg::pal_result_t  res,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output pal_pkg::pal_word_t    mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  pal_pkg::pal_word_t    mem_rdata
);
  import pal_pkg::*;

  // compare width covers both the position field and the count
  localparam int WW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  pal_state_t state, state_next;

  pal_mode_t   cmd_mode;
  pal_word_t   cmd_value;
  logic [WW-1:0] cmd_pos;
  logic [CW-1:0] count;
  logic [AW-1:0] cursor;
  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  pal_word_t     rdv;
  pal_status_t   stat;

  logic [WW-1:0] count_w;
  logic [WW-1:0] cursor_w;
  logic [CW-1:0] count_m1;
  logic          pos_ge, pos_gt, pos_eq, full, is_insert, shift_last, rm_last;
  logic [AW-1:0] cmd_addr;

  always_comb begin
    count_w    = WW'(count);
    cursor_w   = WW'(cursor);
    count_m1   = count - 1'b1;
    pos_ge     = cmd_pos >= count_w;
    pos_gt     = cmd_pos > count_w;
    pos_eq     = cmd_pos == count_w;
    full       = count >= CAP_C;
    is_insert  = cmd_mode == MODE_INSERT;
    cmd_addr   = cmd_pos[AW-1:0];
    rm_last    = (cmd_pos + 1'b1) == count_w;
    // insert walks down to the target slot, remove walks up to the top entry
    shift_last = is_insert ? (cursor_w == cmd_pos) : (CW'(cursor) == count_m1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (cmd_mode)
          MODE_INSERT: state_next = (!pos_gt && !full && !pos_eq) ? S_SHIFT : S_DONE;
          MODE_REMOVE: state_next = (!pos_ge && !rm_last) ? S_SHIFT : S_DONE;
          MODE_READ:   state_next = !pos_ge ? S_READ : S_DONE;
          default:     state_next = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (shift_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = is_insert ? S_FINAL : S_DONE;
      S_FINAL: state_next = S_DONE;
      S_READ:  state_next = S_DONE;
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory port drive
  always_comb begin
    req_stall = state != S_IDLE;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cmd_addr;
    mem_wdata = cmd_value;
    mem_re    = 1'b0;
    mem_raddr = cmd_addr;
    case (state)
      S_EXEC: begin
        case (cmd_mode)
          MODE_APPEND: begin
            mem_we    = !full;
            mem_waddr = count[AW-1:0];
          end
          MODE_INSERT: mem_we = !pos_gt && !full && pos_eq;
          MODE_WRITE:  mem_we = !pos_ge;
          MODE_READ:   mem_re = !pos_ge;
          default: ;
        endcase
      end
      S_SHIFT: begin
        mem_re    = 1'b1;
        mem_raddr = cursor;
      end
      S_FINAL: mem_we = 1'b1;
      S_DONE:  res_valid = res_ready;
      default: ;
    endcase
    // moved entry is written back in the cycle after its read
    if (pend_valid) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = mem_rdata;
    end
  end

  always_comb begin
    res.read_value = rdv;
    res.status     = stat;
    res.count      = count_w[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= state == S_SHIFT;
      pend_addr  <= is_insert ? AW'(cursor + 1'b1) : AW'(cursor - 1'b1);
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_mode  <= mode;
            cmd_value <= value;
            cmd_pos   <= WW'(position);
            stat      <= ST_OK;
            rdv       <= '0;
          end
        end
        S_EXEC: begin
          case (cmd_mode)
            MODE_APPEND: begin
              if (full) stat <= ST_FULL;
              else count <= count + 1'b1;
            end
            MODE_INSERT: begin
              if (pos_gt) stat <= ST_INDEX;
              else if (full) stat <= ST_FULL;
              else if (pos_eq) count <= count + 1'b1;
              else cursor <= count_m1[AW-1:0];
            end
            MODE_REMOVE: begin
              if (pos_ge) stat <= ST_INDEX;
              else if (rm_last) count <= count_m1;
              else cursor <= AW'(cmd_pos + 1'b1);
            end
            MODE_READ, MODE_WRITE: begin
              if (pos_ge) stat <= ST_INDEX;
            end
            default: ;
          endcase
        end
        S_SHIFT: begin
          if (!shift_last) cursor <= is_insert ? AW'(cursor - 1'b1) : AW'(cursor + 1'b1);
        end
        S_DRAIN: begin
          if (!is_insert) count <= count_m1;
        end
        S_FINAL: count <= count + 1'b1;
        S_READ:  rdv   <= mem_rdata;
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("element count above capacity");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    pend_valid && mem_re |-> pend_addr != mem_raddr)
    else $error("shift reads the entry being written back");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_ready)
    else $error("result issued while output register is occupied");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> state == S_IDLE)
    else $error("sequencer did not return to idle after a result");

  a_shift_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> pend_valid)
    else $error("drain without a pending moved entry");

endmodule

@@ src/positional_array_list.sv @@
// Top level of the positional array list: sequencer, element store, result register.
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values in a single-port-per-direction RAM of
// CAPACITY entries. One request beat in, one response beat out. Append,
// write, failed checks, unknown modes, insert at the end and removal of the
// last entry go from the execute state straight to the done state; a read
// passes through the read state; insert at position p moves each entry from p
// up by one, then drains and makes the final write; any other remove moves
// each entry above p down by one, then drains. Insert and remove move one
// entry per cycle through the RAM's read and write ports, so the longest
// operation is insert at position 0 into CAPACITY - 1 entries. A new request
// is taken only when the sequencer is idle; a finished response may still sit
// in the output register while the next request is accepted.
module positional_array_list #(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  pal_pkg::pal_mode_t    mode,
  input  pal_pkg::pal_word_t    value,
  input  pal_pkg::pal_pos_t     position,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output pal_pkg::pal_word_t    read_value,
  output pal_pkg::pal_status_t  status,
  output pal_pkg::pal_count_t   count
);
  import pal_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          res_valid, res_ready;
  pal_result_t   res;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  pal_word_t     mem_wdata, mem_rdata;

  pal_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .value     (value),
    .position  (position),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pal_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // output register is free when empty or being drained this cycle
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      read_value <= res.read_value;
      status     <= res.status;
      count      <= res.count;
    end
  end

endmodule
